// File: hdl/dpf_pkg.sv
// shared types, codes and helpers for the dedup packet fifo
`default_nettype none
package dpf_pkg;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_FWD = 2'd1,
    MODE_CNT = 2'd2,
    MODE_NOP = 2'd3
  } mode_e;

  // hit flags are summed this many cells per scan cycle
  localparam int unsigned GROUP = 8;
  localparam int unsigned LIMIT_BITS = 7;
  localparam int unsigned COUNT_BITS = 7;

  typedef struct packed {
    logic probe;  // latch compare hits against the held request
    logic shift;  // take the entry of the upper neighbor
    logic load;   // write the request into the selected cell
  } cell_ctrl_t;

  function automatic logic [3:0] popcount8(input logic [GROUP-1:0] bits);
    logic [3:0] sum;
    sum = '0;
    for (int k = 0; k < GROUP; k++) begin
      sum = sum + {3'b000, bits[k]};
    end
    return sum;
  endfunction

endpackage
`default_nettype wire

// File: hdl/dpf_cell.sv
// one storage cell of the packet chain with its compare logic
`default_nettype none
module dpf_cell
  import dpf_pkg::*;
#(
  parameter int unsigned IDX       = 0,
  parameter int unsigned IDX_W     = 6,
  parameter int unsigned ID_BITS   = 16,
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cell_ctrl_t           ctrl_i,
  input  wire logic [IDX_W-1:0]     wr_pos_i,
  input  wire logic [ID_BITS-1:0]   req_src_i,
  input  wire logic [ID_BITS-1:0]   req_dst_i,
  input  wire logic [TIME_BITS-1:0] req_ts_i,
  input  wire logic [TIME_BITS-1:0] req_t0_i,
  input  wire logic [TIME_BITS-1:0] req_t1_i,
  input  wire logic [ID_BITS-1:0]   nb_src_i,
  input  wire logic [ID_BITS-1:0]   nb_dst_i,
  input  wire logic [TIME_BITS-1:0] nb_ts_i,
  input  wire logic                 nb_valid_i,
  output logic [ID_BITS-1:0]        src_o,
  output logic [ID_BITS-1:0]        dst_o,
  output logic [TIME_BITS-1:0]      ts_o,
  output logic                      valid_o,
  output logic                      dup_hit_o,
  output logic                      cnt_hit_o
);

  logic [ID_BITS-1:0]   src_q;
  logic [ID_BITS-1:0]   dst_q;
  logic [TIME_BITS-1:0] ts_q;
  logic                 valid_q;
  logic                 dup_hit_q;
  logic                 cnt_hit_q;
  logic                 sel;
  logic                 dup_d;
  logic                 cnt_d;

  assign sel   = (wr_pos_i == IDX_W'(IDX));
  assign dup_d = valid_q && (src_q == req_src_i) && (dst_q == req_dst_i) && (ts_q == req_ts_i);
  assign cnt_d = valid_q && (dst_q == req_dst_i) && (ts_q >= req_t0_i) && (ts_q <= req_t1_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      dup_hit_q <= 1'b0;
      cnt_hit_q <= 1'b0;
    end else begin
      if (ctrl_i.probe) begin
        dup_hit_q <= dup_d;
        cnt_hit_q <= cnt_d;
      end
      if (ctrl_i.shift) begin
        valid_q <= nb_valid_i;
      end
      if (ctrl_i.load && sel) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      src_q <= nb_src_i;
      dst_q <= nb_dst_i;
      ts_q  <= nb_ts_i;
    end
    if (ctrl_i.load && sel) begin
      src_q <= req_src_i;
      dst_q <= req_dst_i;
      ts_q  <= req_ts_i;
    end
  end

  assign src_o     = src_q;
  assign dst_o     = dst_q;
  assign ts_o      = ts_q;
  assign valid_o   = valid_q;
  assign dup_hit_o = dup_hit_q;
  assign cnt_hit_o = cnt_hit_q;

endmodule
`default_nettype wire

// File: hdl/dedup_packet_fifo_with_count_core.sv
// top level of the dedup packet fifo with duplicate check and range count
//
// requests come in on the in channel (in_valid_i / in_stall_o): mode add, forward,
// count or no-op plus the packet fields; a transfer happens when valid is high and
// stall is low. each request gives exactly one result on the out channel
// (out_valid_o / out_stall_i) carrying added, forward flag, forwarded packet and count.
// memory_limit is written over its own channel (cfg_valid_i / cfg_ready_o), always ready.
// entries live in a chain of DEPTH cells, oldest in cell 0; a pop shifts the chain down.
// per request: the request is latched, then every cell compares it in parallel,
// then the hit flags are summed GROUP cells per cycle,
// then the chain is updated and the result register loaded.
// a new request is taken only once the previous one has left its update step.
// the next request is taken while the previous result still waits in the output register.
// a stalled receiver holds the result; the block then waits in its update cycle.
// reset empties the chain, clears fill level and sets memory_limit to 64.
`default_nettype none
module dedup_packet_fifo_with_count_core
  import dpf_pkg::*;
#(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned ID_BITS   = 16,
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // request channel
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [1:0]            mode_i,
  input  wire logic [ID_BITS-1:0]    source_i,
  input  wire logic [ID_BITS-1:0]    destination_i,
  input  wire logic [TIME_BITS-1:0]  timestamp_i,
  input  wire logic [TIME_BITS-1:0]  start_time_i,
  input  wire logic [TIME_BITS-1:0]  end_time_i,
  // result channel
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       added_o,
  output logic                       forward_valid_o,
  output logic [ID_BITS-1:0]         out_source_o,
  output logic [ID_BITS-1:0]         out_destination_o,
  output logic [TIME_BITS-1:0]       out_timestamp_o,
  output logic [COUNT_BITS-1:0]      match_count_o,
  // configuration channel
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [LIMIT_BITS-1:0] memory_limit_i
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > LIMIT_BITS) ? CNT_W : LIMIT_BITS;
  localparam int unsigned NG    = (DEPTH + GROUP - 1) / GROUP;
  localparam int unsigned GI_W  = (NG > 1) ? $clog2(NG) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_SCAN,
    S_APPLY
  } state_e;

  state_e                  state_q;
  mode_e                   mode_q;
  logic [ID_BITS-1:0]      src_q;
  logic [ID_BITS-1:0]      dst_q;
  logic [TIME_BITS-1:0]    ts_q;
  logic [TIME_BITS-1:0]    t0_q;
  logic [TIME_BITS-1:0]    t1_q;
  logic [CNT_W-1:0]        fill_q;
  logic [CNT_W-1:0]        fill_d;
  logic [LIMIT_BITS-1:0]   limit_q;
  logic [GI_W-1:0]         grp_q;
  logic [CNT_W-1:0]        acc_q;
  logic                    dup_q;
  logic                    out_valid_q;
  logic                    added_q;
  logic                    fwd_q;
  logic [ID_BITS-1:0]      osrc_q;
  logic [ID_BITS-1:0]      odst_q;
  logic [TIME_BITS-1:0]    ots_q;
  logic [COUNT_BITS-1:0]   ocnt_q;

  // chain wiring, index DEPTH is the empty slot above the top cell
  logic [ID_BITS-1:0]      c_src   [DEPTH+1];
  logic [ID_BITS-1:0]      c_dst   [DEPTH+1];
  logic [TIME_BITS-1:0]    c_ts    [DEPTH+1];
  logic [DEPTH:0]          c_valid;
  logic [NG*GROUP-1:0]     dup_hits;
  logic [NG*GROUP-1:0]     cnt_hits;

  cell_ctrl_t              ctrl;
  logic [IDX_W-1:0]        wr_pos;
  logic [CMP_W-1:0]        lim_ext;
  logic [CMP_W-1:0]        eff_lim;
  logic                    evict;
  logic                    apply_go;
  logic                    add_ok;
  logic                    fwd_ok;
  logic [GROUP-1:0]        dup_grp;
  logic [GROUP-1:0]        cnt_grp;

  // effective limit: zero acts as one, anything above DEPTH acts as DEPTH
  assign lim_ext = CMP_W'(limit_q);
  always_comb begin
    eff_lim = lim_ext;
    if (lim_ext == '0) begin
      eff_lim = CMP_W'(1);
    end else if (lim_ext > CMP_W'(DEPTH)) begin
      eff_lim = CMP_W'(DEPTH);
    end
  end

  assign evict  = (CMP_W'(fill_q) >= eff_lim);
  assign wr_pos = evict ? IDX_W'(fill_q - CNT_W'(1)) : IDX_W'(fill_q);

  assign apply_go = (state_q == S_APPLY) && !(out_valid_q && out_stall_i);
  assign add_ok   = (mode_q == MODE_ADD) && !dup_q;
  assign fwd_ok   = (mode_q == MODE_FWD) && (fill_q != '0);

  assign ctrl.probe = (state_q == S_PROBE);
  assign ctrl.shift = apply_go && ((add_ok && evict) || fwd_ok);
  assign ctrl.load  = apply_go && add_ok;

  // fill level: an evicting add keeps it, a plain add grows it, a forward shrinks it
  always_comb begin
    fill_d = fill_q;
    if (apply_go) begin
      if (add_ok && !evict) begin
        fill_d = fill_q + CNT_W'(1);
      end else if (fwd_ok) begin
        fill_d = fill_q - CNT_W'(1);
      end
    end
  end

  assign c_src[DEPTH]   = '0;
  assign c_dst[DEPTH]   = '0;
  assign c_ts[DEPTH]    = '0;
  assign c_valid[DEPTH] = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    dpf_cell #(
      .IDX       (g),
      .IDX_W     (IDX_W),
      .ID_BITS   (ID_BITS),
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .wr_pos_i   (wr_pos),
      .req_src_i  (src_q),
      .req_dst_i  (dst_q),
      .req_ts_i   (ts_q),
      .req_t0_i   (t0_q),
      .req_t1_i   (t1_q),
      .nb_src_i   (c_src[g+1]),
      .nb_dst_i   (c_dst[g+1]),
      .nb_ts_i    (c_ts[g+1]),
      .nb_valid_i (c_valid[g+1]),
      .src_o      (c_src[g]),
      .dst_o      (c_dst[g]),
      .ts_o       (c_ts[g]),
      .valid_o    (c_valid[g]),
      .dup_hit_o  (dup_hits[g]),
      .cnt_hit_o  (cnt_hits[g])
    );
  end

  // pad the hit vectors out to whole groups
  for (genvar p = DEPTH; p < NG * GROUP; p++) begin : g_pad
    assign dup_hits[p] = 1'b0;
    assign cnt_hits[p] = 1'b0;
  end

  assign dup_grp = dup_hits[grp_q*GROUP +: GROUP];
  assign cnt_grp = cnt_hits[grp_q*GROUP +: GROUP];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_NOP;
      src_q       <= '0;
      dst_q       <= '0;
      ts_q        <= '0;
      t0_q        <= '0;
      t1_q        <= '0;
      fill_q      <= '0;
      limit_q     <= LIMIT_BITS'(64);
      grp_q       <= '0;
      acc_q       <= '0;
      dup_q       <= 1'b0;
      out_valid_q <= 1'b0;
      added_q     <= 1'b0;
      fwd_q       <= 1'b0;
      osrc_q      <= '0;
      odst_q      <= '0;
      ots_q       <= '0;
      ocnt_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        limit_q <= memory_limit_i;
      end
      // result taken and no new one loaded this cycle
      if (out_valid_q && !out_stall_i && !apply_go) begin
        out_valid_q <= 1'b0;
      end
      fill_q <= fill_d;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            mode_q  <= mode_e'(mode_i);
            src_q   <= source_i;
            dst_q   <= destination_i;
            ts_q    <= timestamp_i;
            t0_q    <= start_time_i;
            t1_q    <= end_time_i;
            state_q <= S_PROBE;
          end
        end
        S_PROBE: begin
          grp_q   <= '0;
          acc_q   <= '0;
          dup_q   <= 1'b0;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          acc_q <= acc_q + CNT_W'(popcount8(cnt_grp));
          dup_q <= dup_q | (|dup_grp);
          grp_q <= grp_q + GI_W'(1);
          if (grp_q == GI_W'(NG - 1)) begin
            state_q <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (apply_go) begin
            out_valid_q <= 1'b1;
            added_q     <= add_ok;
            fwd_q       <= fwd_ok;
            osrc_q      <= fwd_ok ? c_src[0] : '0;
            odst_q      <= fwd_ok ? c_dst[0] : '0;
            ots_q       <= fwd_ok ? c_ts[0] : '0;
            ocnt_q      <= (mode_q == MODE_CNT) ? COUNT_BITS'(acc_q) : '0;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign cfg_ready_o       = 1'b1;
  assign out_valid_o       = out_valid_q;
  assign added_o           = added_q;
  assign forward_valid_o   = fwd_q;
  assign out_source_o      = osrc_q;
  assign out_destination_o = odst_q;
  assign out_timestamp_o   = ots_q;
  assign match_count_o     = ocnt_q;

  // valid cells always form the contiguous run counted by the fill level
  a_fill_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(c_valid) == int'(fill_q))
    else $error("fill level disagrees with valid cells");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(DEPTH))
    else $error("fill level above depth");

  // a result reports at most one kind of outcome
  a_one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && added_o |-> !forward_valid_o && (match_count_o == '0))
    else $error("add result carries forward or count data");

  // an accepted request blocks the next one while it is worked on
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while busy");

  a_fwd_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.shift |-> c_valid[0])
    else $error("chain shifted while empty");

endmodule
`default_nettype wire
